[design/vector3_alu_assert.svh]
// Assertion macros used by the vector ALU checker.
`ifndef VECTOR3_ALU_ASSERT_SVH
`define VECTOR3_ALU_ASSERT_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define VEC3ALU_ASSERT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("vector3_alu check failed");

// Implication into the next cycle, disabled while reset is asserted.
`define VEC3ALU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("vector3_alu check failed");

`endif

[design/vec3alu_pkg.sv]
// Package with the beat types, mode codes and pipeline context of the vector ALU.
`timescale 1ns / 1ps
package vec3alu_pkg;

    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_SUB   = 3'd1;
    localparam logic [2:0] MODE_DOT   = 3'd2;
    localparam logic [2:0] MODE_CROSS = 3'd3;
    localparam logic [2:0] MODE_LEN   = 3'd4;
    localparam logic [2:0] MODE_UNIT  = 3'd5;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] scalar_out;
        logic               zero_length;
        logic               overflow;
    } out_t;

    typedef struct packed {
        logic [2:0]       mode;
        logic [2:0][31:0] a;
        logic [2:0][31:0] rv;
        logic [31:0]      sc;
        logic             zl;
        logic             ov;
    } ctx_t;

endpackage

[design/vector3_alu.sv]
// Top level of the pipelined three-component fixed-point vector ALU.
//
// Usage: each input beat on s_* carries a mode and two signed vectors a and b;
// each input beat gives exactly one result beat on m_*, in order. Modes are add,
// subtract, dot, cross, length and unit vector, all in signed fixed point with
// FRAC_BITS fractional bits. Sums and products saturate and raise overflow; a
// unit vector of the zero vector gives zeros and raises zero_length.
// Every mode passes through the same stages. Throughput is one beat per cycle
// while m_ready does not stall the output: the
// 32 square-root stages and FRAC_BITS + 2 divider stages each resolve one result
// bit per cycle, with three multiply, sum and round stages ahead of them.
// Reset clears every valid bit; the pipeline is empty and s_ready is high after
// reset. When the receiver holds m_ready low with a result waiting, the whole
// pipeline holds its contents; one further input beat is taken into a skid
// register, after which s_ready drops until the result is taken.
`timescale 1ns / 1ps
module vector3_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  vec3alu_pkg::in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output vec3alu_pkg::out_t  m_data
);

    localparam int SQ_STAGES = 32;
    localparam int QW        = FRAC_BITS + 2;
    localparam int RW        = FRAC_BITS + 36;

    function automatic logic [32:0] round_sat(input logic signed [65:0] s);
        logic signed [65:0] t;
        t = (s + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (t > 66'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (t < -66'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, t[31:0]};
    endfunction

    function automatic logic [32:0] sat33(input logic signed [32:0] s);
        if (s > 33'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (s < -33'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, s[31:0]};
    endfunction

    logic adv;
    logic out_vld_reg;
    vec3alu_pkg::out_t out_reg;

    assign adv = !out_vld_reg || m_ready;

    // Skid register on the input side.
    logic              skid_vld_reg;
    vec3alu_pkg::in_t  skid_reg;
    logic              p0_vld;
    vec3alu_pkg::in_t  p0;

    assign s_ready = !skid_vld_reg;
    assign p0_vld  = skid_vld_reg || s_valid;
    assign p0      = skid_vld_reg ? skid_reg : s_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_vld_reg <= 1'b0;
        end else if (adv) begin
            skid_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            skid_vld_reg <= 1'b1;
        end
        if (!adv && s_valid && s_ready) begin
            skid_reg <= s_data;
        end
    end

    // Stage 1: add and subtract, products.
    logic signed [31:0] av [3];
    logic signed [31:0] bv [3];
    logic signed [63:0] pm_next [3];
    logic signed [63:0] cp_next [3][2];
    vec3alu_pkg::ctx_t c1_next;
    logic [32:0]        as_sat [3];

    assign av[0] = p0.a_x;
    assign av[1] = p0.a_y;
    assign av[2] = p0.a_z;
    assign bv[0] = p0.b_x;
    assign bv[1] = p0.b_y;
    assign bv[2] = p0.b_z;

    always_comb begin
        c1_next      = '0;
        c1_next.mode = p0.mode;
        for (int i = 0; i < 3; i++) begin
            c1_next.a[i] = av[i];
            pm_next[i] = av[i] * ((p0.mode == vec3alu_pkg::MODE_LEN ||
                                   p0.mode == vec3alu_pkg::MODE_UNIT) ? av[i] : bv[i]);
            cp_next[i][0] = av[(i + 1) % 3] * bv[(i + 2) % 3];
            cp_next[i][1] = av[(i + 2) % 3] * bv[(i + 1) % 3];
            as_sat[i] = sat33((p0.mode == vec3alu_pkg::MODE_SUB)
                              ? (33'(av[i]) - 33'(bv[i]))
                              : (33'(av[i]) + 33'(bv[i])));
            if (p0.mode == vec3alu_pkg::MODE_ADD || p0.mode == vec3alu_pkg::MODE_SUB) begin
                c1_next.rv[i] = as_sat[i][31:0];
                c1_next.ov    = c1_next.ov | as_sat[i][32];
            end
        end
    end

    logic               v1_reg;
    vec3alu_pkg::ctx_t  c1_reg;
    logic signed [63:0] pm_reg [3];
    logic signed [63:0] cp_reg [3][2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= p0_vld;
        end
        if (adv) begin
            c1_reg <= c1_next;
            pm_reg <= pm_next;
            cp_reg <= cp_next;
        end
    end

    // Stage 2: exact sums.
    logic               v2_reg;
    vec3alu_pkg::ctx_t  c2_reg;
    logic signed [65:0] dsum_reg;
    logic signed [64:0] csum_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            c2_reg   <= c1_reg;
            dsum_reg <= 66'(pm_reg[0]) + 66'(pm_reg[1]) + 66'(pm_reg[2]);
            for (int i = 0; i < 3; i++) begin
                csum_reg[i] <= 65'(cp_reg[i][0]) - 65'(cp_reg[i][1]);
            end
        end
    end

    // Stage 3: rounding of dot and cross, start of the square root.
    vec3alu_pkg::ctx_t c3_next;
    logic [32:0]       dot_rs;
    logic [32:0]       crs_rs [3];

    always_comb begin
        c3_next = c2_reg;
        dot_rs  = round_sat(dsum_reg);
        for (int i = 0; i < 3; i++) begin
            crs_rs[i] = round_sat(66'(csum_reg[i]));
        end
        case (c2_reg.mode)
            vec3alu_pkg::MODE_DOT: begin
                c3_next.sc = dot_rs[31:0];
                c3_next.ov = dot_rs[32];
            end
            vec3alu_pkg::MODE_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    c3_next.rv[i] = crs_rs[i][31:0];
                end
                c3_next.ov = crs_rs[0][32] | crs_rs[1][32] | crs_rs[2][32];
            end
            default: begin
            end
        endcase
    end

    logic              sq_v_reg   [SQ_STAGES + 1];
    vec3alu_pkg::ctx_t sq_c_reg   [SQ_STAGES + 1];
    logic [63:0]       sq_rad_reg [SQ_STAGES + 1];
    logic [63:0]       sq_res_reg [SQ_STAGES + 1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_v_reg[0] <= v2_reg;
        end
        if (adv) begin
            sq_c_reg[0]   <= c3_next;
            sq_rad_reg[0] <= dsum_reg[63:0];
            sq_res_reg[0] <= '0;
        end
    end

    // Square root, one result bit per stage.
    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
        localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        logic [63:0] rad_next;
        logic [63:0] res_next;

        always_comb begin
            trial = sq_res_reg[k] + SQ_BIT;
            if (sq_rad_reg[k] >= trial) begin
                rad_next = sq_rad_reg[k] - trial;
                res_next = (sq_res_reg[k] >> 1) + SQ_BIT;
            end else begin
                rad_next = sq_rad_reg[k];
                res_next = sq_res_reg[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[k + 1] <= 1'b0;
            end else if (adv) begin
                sq_v_reg[k + 1] <= sq_v_reg[k];
            end
            if (adv) begin
                sq_c_reg[k + 1]   <= sq_c_reg[k];
                sq_rad_reg[k + 1] <= rad_next;
                sq_res_reg[k + 1] <= res_next;
            end
        end
    end

    // Length rounding and length result.
    logic [32:0]       len_next;
    logic [32:0]       len_sat;
    vec3alu_pkg::ctx_t cl_next;

    always_comb begin
        len_next = sq_res_reg[SQ_STAGES][32:0]
                 + 33'(sq_rad_reg[SQ_STAGES] > sq_res_reg[SQ_STAGES]);
        len_sat  = sat33(len_next);
        cl_next  = sq_c_reg[SQ_STAGES];
        if (cl_next.mode == vec3alu_pkg::MODE_LEN) begin
            cl_next.sc = len_sat[31:0];
            cl_next.ov = len_sat[32];
        end else if (cl_next.mode == vec3alu_pkg::MODE_UNIT && len_next == '0) begin
            cl_next.zl = 1'b1;
        end
    end

    logic              vl_reg;
    vec3alu_pkg::ctx_t cl_reg;
    logic [32:0]       len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vl_reg <= 1'b0;
        end else if (adv) begin
            vl_reg <= sq_v_reg[SQ_STAGES];
        end
        if (adv) begin
            cl_reg  <= cl_next;
            len_reg <= len_next;
        end
    end

    // Divider setup and restoring division, one quotient bit per stage.
    logic              dv_reg  [QW + 1];
    vec3alu_pkg::ctx_t dc_reg  [QW + 1];
    logic [33:0]       den_reg [QW + 1];
    logic [RW-1:0]     rem_reg [QW + 1][3];
    logic [QW-1:0]     quo_reg [QW + 1][3];
    logic              neg_reg [QW + 1][3];
    logic [31:0]       mag     [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = cl_reg.a[i][31] ? (~cl_reg.a[i] + 32'd1) : cl_reg.a[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_reg[0] <= vl_reg;
        end
        if (adv) begin
            dc_reg[0]  <= cl_reg;
            den_reg[0] <= {len_reg, 1'b0};
            for (int i = 0; i < 3; i++) begin
                rem_reg[0][i] <= (RW'(mag[i]) << (FRAC_BITS + 1)) + RW'(len_reg);
                quo_reg[0][i] <= '0;
                neg_reg[0][i] <= cl_reg.a[i][31];
            end
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int SH = QW - 1 - j;
        logic [RW-1:0] dsh;
        logic          ge   [3];
        logic [RW-1:0] rem_next [3];

        assign dsh = RW'(den_reg[j]) << SH;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                ge[i]       = rem_reg[j][i] >= dsh;
                rem_next[i] = ge[i] ? (rem_reg[j][i] - dsh) : rem_reg[j][i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j + 1] <= 1'b0;
            end else if (adv) begin
                dv_reg[j + 1] <= dv_reg[j];
            end
            if (adv) begin
                dc_reg[j + 1]  <= dc_reg[j];
                den_reg[j + 1] <= den_reg[j];
                for (int i = 0; i < 3; i++) begin
                    rem_reg[j + 1][i] <= rem_next[i];
                    quo_reg[j + 1][i] <= {quo_reg[j][i][QW-2:0], ge[i]};
                    neg_reg[j + 1][i] <= neg_reg[j][i];
                end
            end
        end
    end

    // Output register.
    vec3alu_pkg::ctx_t co;
    logic [31:0]       qv [3];
    vec3alu_pkg::out_t out_next;

    always_comb begin
        co = dc_reg[QW];
        for (int i = 0; i < 3; i++) begin
            qv[i] = 32'(quo_reg[QW][i]);
            if (co.mode == vec3alu_pkg::MODE_UNIT && !co.zl) begin
                co.rv[i] = neg_reg[QW][i] ? (~qv[i] + 32'd1) : qv[i];
            end
        end
        out_next.r_x         = co.rv[0];
        out_next.r_y         = co.rv[1];
        out_next.r_z         = co.rv[2];
        out_next.scalar_out  = co.sc;
        out_next.zero_length = co.zl;
        out_next.overflow    = co.ov;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= dv_reg[QW];
        end
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule

[design/vec3alu_chk.sv]
// Port-level checker for the vector ALU and its bind to the top level.
`timescale 1ns / 1ps
`include "vector3_alu_assert.svh"
module vec3alu_chk (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input vec3alu_pkg::out_t m_data
);

    `VEC3ALU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `VEC3ALU_ASSERT(a_zero_len, aclk, aresetn, m_valid && m_data.zero_length, m_data.r_x == 0 && m_data.r_y == 0 && m_data.r_z == 0 && m_data.scalar_out == 0 && !m_data.overflow)
    `VEC3ALU_ASSERT(a_flags_excl, aclk, aresetn, m_valid && m_data.overflow, !m_data.zero_length)
    `VEC3ALU_ASSERT(a_skid_stall, aclk, aresetn, !s_ready, m_valid)

endmodule

bind vector3_alu vec3alu_chk u_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
